### design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ppir_pkg.sv
// types and constants of the parallel port register model
package ppir_pkg;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_STATUS = 2'd2
   } opcode_type;

   localparam logic [3:0] PORT_A    = 4'd0;
   localparam logic [3:0] PORT_B    = 4'd1;
   localparam logic [3:0] PORT_C    = 4'd2;
   localparam logic [3:0] PORT_CTRL = 4'd3;

   localparam logic [7:0] LATCH_A_RESET = 8'h00;
   localparam logic [7:0] LATCH_B_RESET = 8'hff;
   localparam logic [7:0] LATCH_C_RESET = 8'hff;
   localparam logic [7:0] MODE_RESET    = 8'h82;
   localparam logic [7:0] STATUS_RESET  = 8'h00;
   localparam logic [7:0] HIGH_PORT_READ = 8'hff;

   localparam logic [7:0] STATUS_BUSY = 8'h40;
   localparam logic [7:0] STATUS_DONE = 8'h01;

   localparam int MODE_SET_BIT  = 7;
   localparam int PORT_B_IN_BIT = 1;
   localparam int BIT_VALUE_BIT = 0;
   localparam int PULSE_BIT     = 5;
   localparam int WIDTH_BIT     = 6;

   typedef struct packed {
      logic [1:0] opcode;
      logic [3:0] port_index;
      logic [7:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       mode_latch_pulse;
      logic       width_change;
      logic       width_select;
   } rsp_item_type;

endpackage

### design/ppir_if.sv
// request and response channel interfaces

interface ppir_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [3:0] port_index;
   logic [7:0] write_data;

   modport source (output valid, output opcode, output port_index, output write_data,
                   input ready);
   modport sink   (input valid, input opcode, input port_index, input write_data,
                   output ready);
endinterface

interface ppir_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       mode_latch_pulse;
   logic       width_change;
   logic       width_select;

   modport source (output valid, output read_data, output mode_latch_pulse,
                   output width_change, output width_select, input ready);
   modport sink   (input valid, input read_data, input mode_latch_pulse,
                   input width_change, input width_select, output ready);
endinterface

### design/ppir_in_stage.sv
// input register for request words
module ppir_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  ppir_pkg::req_item_type in_item,
   output logic                  in_ready,
   input  logic                  advance,
   output logic                  item_valid,
   output ppir_pkg::req_item_type item
);
   import ppir_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // stage empties or moves on when the core advances
   assign in_ready = !valid_ff || advance;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

### design/ppir_core.sv
// port latches, mode word, status byte and the access decode
module ppir_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  ppir_pkg::req_item_type item,
   output ppir_pkg::rsp_item_type result
);
   import ppir_pkg::*;

   logic [7:0] latch_a_ff, latch_b_ff, latch_c_ff, mode_ff, status_ff;
   logic [7:0] latch_a_in, latch_b_in, latch_c_in, mode_in, status_in;
   logic [7:0] bit_mask;
   logic [7:0] next_c;
   logic       c_update;
   logic       is_write;
   logic       is_read;

   assign is_write = (item.opcode == OP_WRITE);
   assign is_read  = (item.opcode == OP_READ);

   // single bit set/reset of port c from a control word
   assign bit_mask = 8'h01 << item.write_data[3:1];

   always_comb begin
      latch_a_in = latch_a_ff;
      latch_b_in = latch_b_ff;
      mode_in    = mode_ff;
      status_in  = status_ff;
      next_c     = latch_c_ff;
      c_update   = 1'b0;
      result     = '0;

      // write decode
      if (is_write) begin
         unique case (item.port_index)
            PORT_A: latch_a_in = item.write_data;
            PORT_B: latch_b_in = item.write_data;
            PORT_C: begin
               next_c   = item.write_data;
               c_update = 1'b1;
            end
            PORT_CTRL: begin
               if (item.write_data[MODE_SET_BIT]) begin
                  mode_in = item.write_data;
               end else begin
                  c_update = 1'b1;
                  next_c   = item.write_data[BIT_VALUE_BIT] ? (latch_c_ff | bit_mask)
                                                            : (latch_c_ff & ~bit_mask);
               end
            end
            default: ;
         endcase
      end

      // read decode
      if (is_read) begin
         unique case (item.port_index)
            PORT_A: result.read_data = latch_a_ff;
            PORT_B: begin
               if (mode_ff[PORT_B_IN_BIT]) begin
                  result.read_data = status_ff;
                  status_in        = (status_ff & ~STATUS_BUSY) | STATUS_DONE;
               end else begin
                  result.read_data = latch_b_ff;
               end
            end
            PORT_C:    result.read_data = latch_c_ff;
            PORT_CTRL: result.read_data = mode_ff;
            default:   result.read_data = HIGH_PORT_READ;
         endcase
      end

      // status load from the machine
      if (item.opcode == OP_STATUS) begin
         status_in = item.write_data;
      end

      // port c edge reporting
      if (c_update) begin
         result.mode_latch_pulse = latch_c_ff[PULSE_BIT] && !next_c[PULSE_BIT];
         result.width_change     = latch_c_ff[WIDTH_BIT] ^ next_c[WIDTH_BIT];
         result.width_select     = next_c[WIDTH_BIT];
      end
   end

   assign latch_c_in = next_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_a_ff <= LATCH_A_RESET;
         latch_b_ff <= LATCH_B_RESET;
         latch_c_ff <= LATCH_C_RESET;
         mode_ff    <= MODE_RESET;
         status_ff  <= STATUS_RESET;
      end else if (fire) begin
         latch_a_ff <= latch_a_in;
         latch_b_ff <= latch_b_in;
         latch_c_ff <= latch_c_in;
         mode_ff    <= mode_in;
         status_ff  <= status_in;
      end
   end
endmodule

### design/ppir_out_stage.sv
// result register for response words
module ppir_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   input  ppir_pkg::rsp_item_type load_item,
   output logic                  can_load,
   output logic                  out_valid,
   output ppir_pkg::rsp_item_type out_item,
   input  logic                  out_ready
);
   import ppir_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   // register frees up as soon as the sink takes the word
   assign can_load = !valid_ff || out_ready;
   assign valid_in = can_load ? load_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (can_load && load_valid) begin
         item_ff <= load_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

### design/parallel_port_interface_regs.sv
// top level of the parallel port register model
//
//   channel    dir  fields                                                  handshake
//   req_chan   in   opcode, port_index, write_data                          valid/ready
//   rsp_chan   out  read_data, mode_latch_pulse, width_change, width_select valid/ready
//
// one word per cycle sustained while the response side takes words; a response
// follows its taken request through the input register, decode and result register
// the latch, mode and status registers update as a word passes from the input
// register to the result register
// synchronous reset restores the port latches, mode word 0x82 and a zero status byte
// a stalled response holds both registers; ready then falls on the request side
module parallel_port_interface_regs (
   input  logic       clock,
   input  logic       reset,
   ppir_req_if.sink   req_chan,
   ppir_rsp_if.source rsp_chan
);
   import ppir_pkg::*;

   req_item_type req_item;
   req_item_type stage_item;
   rsp_item_type core_result;
   rsp_item_type rsp_item;
   logic         stage_valid;
   logic         can_load;
   logic         req_ready;
   logic         rsp_valid;

   assign req_item.opcode     = req_chan.opcode;
   assign req_item.port_index = req_chan.port_index;
   assign req_item.write_data = req_chan.write_data;

   // request register
   ppir_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_item    (req_item),
      .in_ready   (req_ready),
      .advance    (can_load),
      .item_valid (stage_valid),
      .item       (stage_item)
   );

   assign req_chan.ready = req_ready;

   // register file and decode
   ppir_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (stage_valid && can_load),
      .item   (stage_item),
      .result (core_result)
   );

   // response register
   ppir_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (stage_valid),
      .load_item  (core_result),
      .can_load   (can_load),
      .out_valid  (rsp_valid),
      .out_item   (rsp_item),
      .out_ready  (rsp_chan.ready)
   );

   assign rsp_chan.valid            = rsp_valid;
   assign rsp_chan.read_data        = rsp_item.read_data;
   assign rsp_chan.mode_latch_pulse = rsp_item.mode_latch_pulse;
   assign rsp_chan.width_change     = rsp_item.width_change;
   assign rsp_chan.width_select     = rsp_item.width_select;
endmodule

### design/ppir_checker.sv
// port level checks for the parallel port register model
`include "assert_macros.svh"

module ppir_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data,
   input logic       rsp_mode_latch_pulse,
   input logic       rsp_width_change,
   input logic       rsp_width_select
);

   // no response word survives reset
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

   // a stalled response keeps its word
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data), "stalled response changed")

   // a fresh response follows a taken request, by way of the input and result registers
   `ASSERT_CLK(a_rsp_origin, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2), "response without request")

   // port c reports only come from writes, which return no data
   `ASSERT_CLK(a_write_no_data, clock, reset, rsp_valid && (rsp_mode_latch_pulse || rsp_width_change || rsp_width_select) |-> rsp_read_data == 8'h00, "port c report with read data")

endmodule

bind parallel_port_interface_regs ppir_checker u_ppir_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_chan.valid),
   .req_ready            (req_chan.ready),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_read_data        (rsp_chan.read_data),
   .rsp_mode_latch_pulse (rsp_chan.mode_latch_pulse),
   .rsp_width_change     (rsp_chan.width_change),
   .rsp_width_select     (rsp_chan.width_select)
);
